/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define MFPS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define MFPS_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/mfps_pkg.sv */
// ----------------------------------------------------------------------------
// mfps_pkg
// Fixed widths, reset values and control types of the falling path sum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfps_pkg;

    localparam int CFG_W = 7;
    localparam int OUT_W = 22;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Position flags of an element, carried alongside it into the compute stage.
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic col0;
        logic has_left;
        logic has_right;
        logic matrix_end;
    } t_pos_ctl;

endpackage

`default_nettype wire

/* design/mfps_elem_if.sv */
// ----------------------------------------------------------------------------
// mfps_elem_if
// Valid/ready channel that carries one matrix element a beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mfps_elem_if #(
    parameter int ELEMENT_BITS = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [ELEMENT_BITS-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
    modport mon    (input valid, input element, input ready);
endinterface

`default_nettype wire

/* design/mfps_res_if.sv */
// ----------------------------------------------------------------------------
// mfps_res_if
// Valid/ready channel that carries one minimum path sum a beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mfps_res_if;
    import mfps_pkg::*;

    logic              valid;
    logic              ready;
    logic signed [OUT_W-1:0] path_min;

    modport source (output valid, output path_min, input ready);
    modport sink   (input valid, input path_min, output ready);
    modport mon    (input valid, input path_min, input ready);
endinterface

`default_nettype wire

/* design/mfps_ram.sv */
// ----------------------------------------------------------------------------
// mfps_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfps_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/min_falling_path_sum.sv */
// ----------------------------------------------------------------------------
// min_falling_path_sum
// Streams a square matrix in row-major order and returns its minimum falling
// path sum after the last element.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  --------  ---------  ---------------------------------------------------
//  i_elem    in         element: one signed matrix element, row-major order
//  o_res     out        path_min: minimum falling path sum of the matrix
//  i_cfg_*   in         matrix_size: rows and columns (write only)
//
//  One element is taken every clock cycle while the compute stage is not held;
//  the rate is set by the single read port of the row store, which is read one
//  column ahead of each element. Each result waits in an output register.
//  Reset is synchronous and active low. It clears the control state only; the
//  row store has no clearing pass, since every entry is written before it is
//  read. A stalled result holds the compute stage only when that stage holds
//  the last element of the next matrix; other elements keep flowing.
//
`timescale 1ns / 1ps
`default_nettype none

module min_falling_path_sum #(
    parameter int MAX_SIZE     = 64,
    parameter int ELEMENT_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [mfps_pkg::CFG_W-1:0] i_cfg_data,
    mfps_elem_if.sink                      i_elem,
    mfps_res_if.source                     o_res
);
    import mfps_pkg::*;

    // Column and row positions need enough bits to index MAX_SIZE entries.
    localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    // A path sum is at most MAX_SIZE elements, plus a sign guard bit.
    localparam int SUM_W  = ELEMENT_BITS + IDX_W + 1;
    localparam int WIDE_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam int RESET_SIZE = (int'(CFG_RESET) > MAX_SIZE) ? MAX_SIZE : int'(CFG_RESET);
    localparam logic [IDX_W-1:0] RESET_LAST = IDX_W'(RESET_SIZE - 1);
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

    // ------------------------------------------------------------------------
    // Configuration: the register holds the index of the last row and column.
    // A zero size behaves as one, and a size above MAX_SIZE saturates.
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0] r_last_idx;
    logic [IDX_W-1:0] n_last_idx;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_last_idx = '0;
        end else if (int'(i_cfg_data) > MAX_SIZE) begin
            n_last_idx = IDX_W'(MAX_SIZE - 1);
        end else begin
            n_last_idx = IDX_W'(int'(i_cfg_data) - 1);
        end
    end

    // ------------------------------------------------------------------------
    // Input side: position counters and the look-ahead read of the row store.
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0] r_col_idx;
    logic [IDX_W-1:0] r_row_idx;
    logic             accept;
    logic             advance;
    t_pos_ctl         pos_ctl;
    logic [IDX_W-1:0] rd_addr;

    always_comb begin
        pos_ctl.first_row  = (r_row_idx == '0);
        pos_ctl.last_row   = (r_row_idx == r_last_idx);
        pos_ctl.col0       = (r_col_idx == '0);
        pos_ctl.has_left   = (r_col_idx != '0);
        pos_ctl.has_right  = (r_col_idx != r_last_idx);
        pos_ctl.matrix_end = pos_ctl.last_row && !pos_ctl.has_right;
        // The right-hand neighbour of the row above; when there is none the
        // address is kept in range and the data is ignored.
        rd_addr = pos_ctl.has_right ? r_col_idx + 1'b1 : r_col_idx;
    end

    // ------------------------------------------------------------------------
    // Compute stage registers.
    // ------------------------------------------------------------------------
    logic                     r_s1_v;
    logic signed [ELEMENT_BITS-1:0] r_s1_elem;
    logic [IDX_W-1:0]         r_s1_col;
    t_pos_ctl                 r_s1_ctl;

    // Values of the row above around the current column, as they stood
    // before this row overwrote them.
    logic signed [SUM_W-1:0]  r_left;
    logic signed [SUM_W-1:0]  r_above;
    logic signed [SUM_W-1:0]  r_col0_sum;
    logic signed [SUM_W-1:0]  r_run_min;

    // Forwarding of a write that lands on the address being read.
    logic                     r_byp_v;
    logic signed [SUM_W-1:0]  r_byp_data;

    logic signed [SUM_W-1:0]  ram_q;
    logic signed [SUM_W-1:0]  right;
    logic signed [SUM_W-1:0]  above;
    logic signed [SUM_W-1:0]  best;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  final_min;
    logic signed [WIDE_W-1:0] final_wide;
    logic                     wr_en;

    logic                     r_out_v;
    logic signed [OUT_W-1:0]  r_out_data;

    // The stage only waits when it holds a matrix end and the result is stuck.
    assign advance = !(r_s1_v && r_s1_ctl.matrix_end && r_out_v && !o_res.ready);
    assign accept  = i_elem.valid && advance;
    assign wr_en   = r_s1_v && advance;

    mfps_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_SIZE),
        .ADDR_W(IDX_W)
    ) u_row_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_s1_col),
        .i_wdata(sum),
        .i_re   (accept),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    always_comb begin
        right = r_byp_v ? r_byp_data : ram_q;
        above = r_s1_ctl.col0 ? r_col0_sum : r_above;
        best  = above;
        if (r_s1_ctl.has_left && (r_left < best)) begin
            best = r_left;
        end
        if (r_s1_ctl.has_right && (right < best)) begin
            best = right;
        end
        if (r_s1_ctl.first_row) begin
            sum = SUM_W'(r_s1_elem);
        end else begin
            sum = SUM_W'(r_s1_elem) + best;
        end
        final_min  = (sum < r_run_min) ? sum : r_run_min;
        final_wide = WIDE_W'(final_min);
    end

    // ------------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= RESET_LAST;
            r_col_idx  <= '0;
            r_row_idx  <= '0;
            r_s1_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_run_min  <= SUM_MAX;
        end else begin
            if (i_cfg_we) begin
                // A new size drops any partial matrix and starts afresh.
                r_last_idx <= n_last_idx;
                r_col_idx  <= '0;
                r_row_idx  <= '0;
                r_run_min  <= SUM_MAX;
            end else begin
                if (accept) begin
                    if (pos_ctl.has_right) begin
                        r_col_idx <= r_col_idx + 1'b1;
                    end else begin
                        r_col_idx <= '0;
                        r_row_idx <= pos_ctl.last_row ? '0 : r_row_idx + 1'b1;
                    end
                end
                if (wr_en) begin
                    if (r_s1_ctl.matrix_end) begin
                        r_run_min <= SUM_MAX;
                    end else if (r_s1_ctl.last_row) begin
                        r_run_min <= final_min;
                    end
                end
            end

            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (advance) begin
                r_s1_v <= 1'b0;
            end

            if (wr_en && r_s1_ctl.matrix_end) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_elem  <= i_elem.element;
            r_s1_col   <= r_col_idx;
            r_s1_ctl   <= pos_ctl;
            r_byp_v    <= wr_en && (r_s1_col == rd_addr);
            r_byp_data <= sum;
        end
        if (wr_en) begin
            r_left  <= above;
            r_above <= right;
            if (r_s1_ctl.col0) begin
                r_col0_sum <= sum;
            end
        end
        if (wr_en && r_s1_ctl.matrix_end) begin
            r_out_data <= final_wide[OUT_W-1:0];
        end
    end

    assign i_elem.ready   = advance;
    assign o_res.valid    = r_out_v;
    assign o_res.path_min = r_out_data;

endmodule

`default_nettype wire

/* design/mfps_checker.sv */
// ----------------------------------------------------------------------------
// mfps_checker
// Port-level checks of the falling path sum block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mfps_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_elem_valid,
    input wire logic                      i_elem_ready,
    input wire logic                      i_res_valid,
    input wire logic                      i_res_ready,
    input wire logic [mfps_pkg::OUT_W-1:0] i_res_data
);

    // A waiting result keeps its value until it is taken.
    `MFPS_ASSERT_RST(a_res_hold, i_clk, i_rst_n,
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data),
        "result changed while stalled")

    // Reset leaves no result pending.
    `MFPS_ASSERT_ALL(a_rst_clear, i_clk, !i_rst_n |=> !i_res_valid,
        "result valid after reset")

    // A new result always follows an element beat, registered in the compute stage and then in the output register.
    `MFPS_ASSERT_RST(a_res_cause, i_clk, i_rst_n,
        $rose(i_res_valid) |-> $past(i_elem_valid && i_elem_ready, 2),
        "result without an element")

    // With the result side empty the block never refuses an element.
    `MFPS_ASSERT_RST(a_ready_free, i_clk, i_rst_n, !i_res_valid |-> i_elem_ready,
        "element refused with no result pending")

endmodule

bind min_falling_path_sum mfps_checker u_mfps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_elem_valid(i_elem.valid),
    .i_elem_ready(i_elem.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.path_min)
);

`default_nettype wire

/* test/tb_min_falling_path_sum.sv */
// ----------------------------------------------------------------------------
// tb_min_falling_path_sum
// Self-checking bench for the minimum falling path sum block. Matrices of many
// sizes are streamed in with random idle gaps on both channels, and every
// returned path sum is compared with an in-bench prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_min_falling_path_sum;
    import mfps_pkg::*;

    localparam int ELEM_W          = 16;
    localparam int MAX_SIZE        = 64;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_ELEMENTS = 1250;
    localparam int SATURATED_BEATS = 2 * MAX_SIZE + 3;
    localparam int SHOW_LIMIT      = 20;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [OUT_W-1:0]  path_t;
    // Row sums are one bit wider than the result, as in the block's row store.
    typedef logic signed [OUT_W:0]    sum_t;
    typedef logic [CFG_W-1:0]         size_t;

    // How the elements of one matrix are chosen.
    typedef enum int {FILL_MAX, FILL_MIN, FILL_MIXED} fill_t;

    localparam elem_t ELEM_MAX = 16'sh7FFF;
    localparam elem_t ELEM_MIN = 16'sh8000;

    // ------------------------------------------------------------------------
    // Path sum tracker: follows the matrix position and the row of best sums
    // exactly as the block should, and queues one expected minimum for every
    // completed matrix.
    // ------------------------------------------------------------------------
    class falling_path_book;
        size_t size_reg;
        sum_t  row_sums[MAX_SIZE];
        sum_t  saved_left;
        sum_t  running_min;
        int    row;
        int    col;
        path_t expected_minima[$];
        int    errors;
        int    elements;
        int    results;
        int    size_writes;

        function new();
            size_reg = CFG_RESET;
            foreach (row_sums[k]) row_sums[k] = '0;
            errors      = 0;
            elements    = 0;
            results     = 0;
            size_writes = 0;
            restart();
        endfunction

        function void restart();
            saved_left  = '0;
            row         = 0;
            col         = 0;
            running_min = {1'b0, {OUT_W{1'b1}}};
        endfunction

        // Size actually used: zero counts as one, anything too big saturates.
        function int side();
            if (size_reg == 0) return 1;
            if (size_reg > MAX_SIZE) return MAX_SIZE;
            return int'(size_reg);
        endfunction

        function void set_size(size_t value);
            size_reg = value;
            size_writes++;
            restart();
        endfunction

        function int pending();
            return expected_minima.size();
        endfunction

        function void take_element(elem_t e);
            int   n;
            int   j;
            sum_t above;
            sum_t best;
            sum_t sum;
            n = side();
            j = col;
            elements++;
            if (j >= n) j = n - 1;
            above = row_sums[j];
            if (row == 0) begin
                sum = e;
            end else begin
                best = above;
                if (j > 0 && saved_left < best) best = saved_left;
                if (j + 1 < n && row_sums[j + 1] < best) best = row_sums[j + 1];
                sum = e + best;
            end
            // Keep the old sum of this column: it is the left neighbour of the next one.
            saved_left  = above;
            row_sums[j] = sum;
            if (row + 1 >= n && sum < running_min) running_min = sum;
            if (j + 1 < n) begin
                col = j + 1;
                return;
            end
            col        = 0;
            saved_left = '0;
            if (row + 1 < n) begin
                row++;
                return;
            end
            expected_minima.push_back(running_min[OUT_W-1:0]);
            restart();
        endfunction

        task report(string what);
            errors++;
            if (errors <= SHOW_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task match_result(path_t got);
            path_t want;
            results++;
            if (expected_minima.size() == 0) begin
                report($sformatf("path_min %0d arrived with no matrix completed", got));
                return;
            end
            want = expected_minima.pop_front();
            if (got !== want) report($sformatf("path_min %0d, expected %0d", got, want));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the channels.
    // ------------------------------------------------------------------------
    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  cfg_we;
    size_t cfg_data;
    // When set, neither side inserts idle cycles, so the block runs flat out.
    bit    quiet = 1'b0;

    falling_path_book book = new();

    mfps_elem_if #(.ELEMENT_BITS(ELEM_W)) elem_ch ();
    mfps_res_if                           res_ch ();

    min_falling_path_sum #(
        .MAX_SIZE     (MAX_SIZE),
        .ELEMENT_BITS (ELEM_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_elem     (elem_ch),
        .o_res      (res_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Helpers for the stimulus.
    // ------------------------------------------------------------------------

    // Mostly back-to-back beats, some short pauses and now and then a long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mixed elements lean towards the full range, with small values, the two
    // extremes and the values around zero thrown in so that ties and sign
    // changes turn up often in the minimum.
    function automatic elem_t draw_element(fill_t fill);
        int r;
        if (fill == FILL_MAX) return ELEM_MAX;
        if (fill == FILL_MIN) return ELEM_MIN;
        r = $urandom_range(0, 9);
        if (r < 5) return elem_t'($urandom);
        if (r < 7) return elem_t'($urandom_range(0, 16) - 8);
        if (r == 7) return ELEM_MAX;
        if (r == 8) return ELEM_MIN;
        return elem_t'($urandom_range(0, 2) - 1);
    endfunction

    // Offers one element and returns at the edge where the beat is taken. If
    // no gap is wanted, valid simply stays high from the previous beat.
    task automatic push_element(elem_t e);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            elem_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        elem_ch.valid   <= 1'b1;
        elem_ch.element <= e;
        @(posedge i_clk);
        while (!elem_ch.ready) @(posedge i_clk);
        book.take_element(e);
    endtask

    // The size register is only written while nothing is in flight.
    task automatic write_size(size_t value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        book.set_size(value);
    endtask

    // Lowers valid, waits for every outstanding path sum and then lets the
    // pipeline run empty, since a partial matrix leaves beats in flight
    // without any result to wait for.
    task automatic settle();
        elem_ch.valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Streams one matrix at the current size. A cut-short matrix stops at a
    // random point so that the next size write has to throw it away.
    task automatic feed_matrix(fill_t fill, bit cut_short);
        int n;
        int count;
        n     = book.side();
        count = n * n;
        if (cut_short) count = (n < 2) ? 0 : $urandom_range(1, n * n - 1);
        for (int k = 0; k < count; k++) push_element(draw_element(fill));
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready is decided afresh every cycle, so stalls can land on
    // a waiting result as well as on empty cycles. A beat is taken when valid
    // and ready were both high in the cycle that has just ended.
    // ------------------------------------------------------------------------
    initial begin
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) book.match_result(res_ch.path_min);
            if (hold > 0) begin
                hold--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0) hold = idle_cycles();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        elem_t corner_values[5];
        elem_t three_by_three[9];
        int    random_start;
        int    r;
        size_t sz;

        corner_values  = '{ELEM_MAX, ELEM_MIN, 16'sd0, -16'sd1, 16'sh5A5A};
        three_by_three = '{ELEM_MIN, ELEM_MAX, 16'sd0,
                           ELEM_MAX, ELEM_MIN, -16'sd1,
                           16'sd5,   ELEM_MAX, ELEM_MIN};

        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_data        <= CFG_RESET;
        elem_ch.valid   <= 1'b0;
        elem_ch.element <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A size of one: every element is its own result, extremes included.
        write_size(size_t'(1));
        foreach (corner_values[k]) push_element(corner_values[k]);
        settle();

        // A size of zero behaves as a size of one.
        write_size(size_t'(0));
        push_element(16'sd12);
        push_element(-16'sd7);
        settle();

        // Two-by-two: both columns sit on an edge, so only two sums compete.
        write_size(size_t'(2));
        push_element(16'sd1);
        push_element(-16'sd2);
        push_element(16'sd3);
        push_element(16'sd4);
        repeat (4) push_element(ELEM_MAX);
        settle();

        // Three-by-three has a middle column with all three neighbours.
        write_size(size_t'(3));
        foreach (three_by_three[k]) push_element(three_by_three[k]);
        settle();

        // A matrix abandoned part way must leave no trace on the next one.
        write_size(size_t'(5));
        feed_matrix(FILL_MIXED, 1'b1);
        settle();
        write_size(size_t'(4));
        feed_matrix(FILL_MIXED, 1'b0);
        settle();

        // An oversized write saturates to the top size. Two full rows and the
        // start of a third run through the last column at that size; the
        // first random size write then drops the matrix.
        write_size(size_t'(127));
        repeat (SATURATED_BEATS) push_element(draw_element(FILL_MIN));
        settle();

        // Random phases: a size, a few whole matrices, and sometimes a
        // trailing partial matrix. Small sizes dominate to keep results coming.
        random_start = book.elements;
        while (book.elements - random_start < RANDOM_ELEMENTS) begin
            quiet = ($urandom_range(0, 3) == 0);
            r     = $urandom_range(0, 19);
            if (r == 0) begin
                sz = '0;
            end else if (r <= 12) begin
                sz = size_t'($urandom_range(1, 5));
            end else if (r <= 17) begin
                sz = size_t'($urandom_range(6, 12));
            end else begin
                sz = size_t'($urandom_range(13, 24));
            end
            write_size(sz);
            repeat ($urandom_range(1, 4)) begin
                if (book.elements - random_start < RANDOM_ELEMENTS) begin
                    r = $urandom_range(0, 7);
                    if (r == 0) begin
                        feed_matrix(FILL_MAX, 1'b0);
                    end else if (r == 1) begin
                        feed_matrix(FILL_MIN, 1'b0);
                    end else begin
                        feed_matrix(FILL_MIXED, 1'b0);
                    end
                end
            end
            if ($urandom_range(0, 4) == 0) feed_matrix(FILL_MIXED, 1'b1);
            settle();
        end

        $display("Run covered %0d element beats and %0d path sums over %0d size writes,",
                 book.elements, book.results, book.size_writes);
        $display("from a size of zero and of one up to a saturated size, with idle gaps.");
        if (book.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest correct run with every gap at its
    // longest.
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/mfps_pkg.sv
design/mfps_elem_if.sv
design/mfps_res_if.sv
design/mfps_ram.sv
design/min_falling_path_sum.sv
design/mfps_checker.sv
test/tb_min_falling_path_sum.sv
